>>> sv/tbfe_pkg.sv
// ---------------------------------------------------------------------------
// Three-band FIR crossover equalizer package
// Shared types and constants for the equalizer modules.
// ---------------------------------------------------------------------------
package tbfe_pkg;

	localparam logic [1:0] MODE_SAMPLE   = 2'd0;
	localparam logic [1:0] MODE_LOW_COEF = 2'd1;
	localparam logic [1:0] MODE_MID_COEF = 2'd2;

	localparam logic [1:0] CFG_BASS   = 2'd0;
	localparam logic [1:0] CFG_MIDDLE = 2'd1;
	localparam logic [1:0] CFG_TREBLE = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] sample_in;
		logic [5:0]         tap_index;
		logic signed [15:0] tap_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] eq_out;
		logic signed [15:0] low_band;
		logic signed [15:0] mid_band;
		logic signed [15:0] high_band;
		logic               clipped;
	} out_item_t;

	// Saturate a 17-bit difference to 16 bits.
	function automatic logic [16:0] sat17(input logic signed [16:0] v);
		logic [16:0] r;
		if (v > 17'sd32767) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -17'sd32768) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

endpackage

>>> sv/tbfe_mac.sv
// ---------------------------------------------------------------------------
// Equalizer multiply-accumulate unit
// Registered 17x17 signed product, then a wide accumulator.
// ---------------------------------------------------------------------------
module tbfe_mac #(
	parameter int ACC_W = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    en,
	input  logic signed [16:0]      a,
	input  logic signed [16:0]      b,
	output logic signed [ACC_W-1:0] acc
);
	logic signed [33:0]      prod_s1;
	logic                    en_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s1 <= en;
			if (clear) begin
				acc_q <= '0;
			end else if (en_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign acc = acc_q;
endmodule

>>> sv/three_band_fir_crossover_eq.sv
// ---------------------------------------------------------------------------
// Three-band FIR crossover equalizer
// Channel   Direction  Payload
// in        input      mode, sample_in, tap_index, tap_value
// out       output     eq_out, low_band, mid_band, high_band, clipped
// cfg       input      bass, middle and treble gains
// A sample is processed by one shared multiplier, which walks both filters'
// taps from synchronous memories, then the three gain products. Coefficient
// writes are done in the idle state. After reset a clearing pass zeroes the
// memories; no transaction is accepted until it ends. A finished result waits
// in the output register while the next transaction is taken; the input stalls
// while a sample is in progress and while a finished result waits for a held
// output register.
// ---------------------------------------------------------------------------
module three_band_fir_crossover_eq #(
	parameter int TAPS = 63
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tbfe_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tbfe_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [tbfe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tbfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tbfe_pkg::*;

	localparam int ALIGN = (TAPS - 1) / 2;
	localparam int AW    = $clog2(TAPS);
	localparam int DW    = (ALIGN > 1) ? $clog2(ALIGN) : 1;
	localparam int ACC_W = 40 + AW;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_COEF  = 9'b000000100,
		ST_LOWR  = 9'b000001000,
		ST_LOWF  = 9'b000010000,
		ST_MIDR  = 9'b000100000,
		ST_MIDF  = 9'b001000000,
		ST_GAIN  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [15:0] bass_q, middle_q, treble_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_q   <= 16'd4096;
			middle_q <= 16'd4096;
			treble_q <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BASS:   bass_q   <= cfg_wdata;
				CFG_MIDDLE: middle_q <= cfg_wdata;
				CFG_TREBLE: treble_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// Memories: histories are circular buffers; coefficients by tap index.
	logic [15:0] lhist_mem [TAPS];
	logic [15:0] mhist_mem [TAPS];
	logic [15:0] lcoef_mem [TAPS];
	logic [15:0] mcoef_mem [TAPS];

	logic          cw_l, cw_m, lw_en, mw_en;
	logic [AW-1:0] hw_addr, cw_addr, rd_addr, h_rd_addr;
	logic [15:0]   lhw_data, mhw_data, cw_data;
	logic [15:0]   lh_rd, mh_rd, lc_rd, mc_rd;

	always_ff @(posedge clk) begin
		if (lw_en) lhist_mem[hw_addr] <= lhw_data;
		if (mw_en) mhist_mem[hw_addr] <= mhw_data;
		if (cw_l)  lcoef_mem[cw_addr] <= cw_data;
		if (cw_m)  mcoef_mem[cw_addr] <= cw_data;
		lh_rd <= lhist_mem[h_rd_addr];
		mh_rd <= mhist_mem[h_rd_addr];
		lc_rd <= lcoef_mem[rd_addr];
		mc_rd <= mcoef_mem[rd_addr];
	end

	// Alignment delay lines as circular buffers of ALIGN entries.
	logic [15:0] ldly_mem [ALIGN];
	logic [15:0] xdly_mem [ALIGN];
	logic [15:0] rdly_mem [ALIGN];
	logic [DW-1:0] dptr_q;
	logic [DW-1:0] dw_addr;
	logic          dw_x, dw_l, dw_r;
	logic [15:0]   dw_data;
	logic [15:0]   ld_rd, xd_rd, rd_rd;

	always_ff @(posedge clk) begin
		if (dw_x) xdly_mem[dw_addr] <= dw_data;
		if (dw_l) ldly_mem[dw_addr] <= dw_data;
		if (dw_r) rdly_mem[dw_addr] <= dw_data;
		ld_rd <= ldly_mem[dptr_q];
		xd_rd <= xdly_mem[dptr_q];
		rd_rd <= rdly_mem[dptr_q];
	end

	logic [AW-1:0] head_q;
	logic [AW:0]   cnt_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    sub_q;
	logic signed [15:0] x_q, rest_q, mid_q, high_q, lowal_q;
	logic          clip_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic signed [16:0]      mac_a, mac_b;
	logic                    mac_clear, mac_en;
	logic signed [ACC_W-1:0] acc;

	tbfe_mac #(.ACC_W(ACC_W)) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (mac_clear),
		.en    (mac_en),
		.a     (mac_a),
		.b     (mac_b),
		.acc   (acc)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic accept;
	assign accept = in_valid && !in_stall;

	// History read address: head plus tap count, modulo TAPS.
	logic [AW:0] h_sum;
	assign h_sum = {1'b0, head_q} + cnt_q;
	assign rd_addr   = cnt_q[AW-1:0];
	assign h_rd_addr = (h_sum >= (AW+1)'(TAPS)) ? AW'(h_sum - (AW+1)'(TAPS))
	                                            : h_sum[AW-1:0];

	// FIR rounding and saturation.
	logic signed [ACC_W-1:0] fir_sh;
	logic [16:0]             fir_sat;
	always_comb begin
		fir_sh = (acc + ACC_W'(16384)) >>> 15;
		if (fir_sh > ACC_W'(32767)) begin
			fir_sat = {1'b1, 16'h7FFF};
		end else if (fir_sh < -ACC_W'(32768)) begin
			fir_sat = {1'b1, 16'h8000};
		end else begin
			fir_sat = {1'b0, fir_sh[15:0]};
		end
	end

	logic signed [ACC_W-1:0] eq_sh;
	logic [16:0]             eq_sat;
	always_comb begin
		eq_sh = (acc + ACC_W'(4096)) >>> 13;
		if (eq_sh > ACC_W'(32767)) begin
			eq_sat = {1'b1, 16'h7FFF};
		end else if (eq_sh < -ACC_W'(32768)) begin
			eq_sat = {1'b1, 16'h8000};
		end else begin
			eq_sat = {1'b0, eq_sh[15:0]};
		end
	end

	logic [16:0] rest_sat, high_sat;
	assign rest_sat = sat17(17'($signed(xd_rd)) - 17'($signed(fir_sat[15:0])));
	assign high_sat = sat17(17'($signed(rd_rd)) - 17'($signed(fir_sat[15:0])));

	logic [AW-1:0] head_prev;
	assign head_prev = (head_q == '0) ? AW'(TAPS - 1) : head_q - AW'(1);

	always_comb begin
		lw_en    = 1'b0;
		mw_en    = 1'b0;
		hw_addr  = head_q;
		lhw_data = 16'h0;
		mhw_data = 16'h0;
		cw_l     = 1'b0;
		cw_m     = 1'b0;
		cw_addr  = AW'(in_data.tap_index);
		cw_data  = in_data.tap_value;
		dw_x     = 1'b0;
		dw_l     = 1'b0;
		dw_r     = 1'b0;
		dw_addr  = dptr_q;
		dw_data  = 16'h0;
		mac_clear = 1'b0;
		mac_en   = 1'b0;
		mac_a    = 17'($signed(lc_rd));
		mac_b    = 17'($signed(lh_rd));
		case (state_q)
			ST_CLEAR: begin
				lw_en   = 1'b1;
				mw_en   = 1'b1;
				hw_addr = clr_q;
				cw_l    = 1'b1;
				cw_m    = 1'b1;
				cw_addr = clr_q;
				cw_data = 16'h0;
				dw_addr = DW'(clr_q);
				if ({1'b0, clr_q} < (AW+1)'(ALIGN)) begin
					dw_x = 1'b1;
					dw_l = 1'b1;
					dw_r = 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept && in_data.mode == MODE_SAMPLE) begin
					lw_en     = 1'b1;
					hw_addr   = head_prev;
					lhw_data  = in_data.sample_in;
					mac_clear = 1'b1;
				end
				if (accept && (in_data.mode == MODE_LOW_COEF ||
				               in_data.mode == MODE_MID_COEF) &&
				    9'(in_data.tap_index) < 9'(TAPS)) begin
					cw_l = (in_data.mode == MODE_LOW_COEF);
					cw_m = (in_data.mode == MODE_MID_COEF);
				end
			end
			ST_LOWR: begin
				mac_en = (sub_q == 3'd0 && cnt_q != '0);
				mac_a  = 17'($signed(lc_rd));
				mac_b  = 17'($signed(lh_rd));
			end
			ST_LOWF: begin
				if (sub_q == 3'd2) begin
					dw_l      = 1'b1;
					dw_data   = fir_sat[15:0];
					mw_en     = 1'b1;
					hw_addr   = head_q;
					mhw_data  = rest_sat[15:0];
					mac_clear = 1'b1;
				end
			end
			ST_MIDR: begin
				mac_en = (sub_q == 3'd0 && cnt_q != '0);
				mac_a  = 17'($signed(mc_rd));
				mac_b  = 17'($signed(mh_rd));
			end
			ST_MIDF: begin
				if (sub_q == 3'd0) begin
					dw_x    = 1'b1;
					dw_data = x_q;
				end
				if (sub_q == 3'd2) begin
					dw_r      = 1'b1;
					dw_data   = rest_q;
					mac_clear = 1'b1;
				end
			end
			ST_GAIN: begin
				mac_en = (sub_q < 3'd3);
				case (sub_q)
					3'd0: begin
						mac_a = $signed({1'b0, bass_q});
						mac_b = 17'(lowal_q);
					end
					3'd1: begin
						mac_a = $signed({1'b0, middle_q});
						mac_b = 17'(mid_q);
					end
					default: begin
						mac_a = $signed({1'b0, treble_q});
						mac_b = 17'(high_q);
					end
				endcase
			end
			default: ;
		endcase
	end

	// Each FIR, low then mid, walks taps 0..TAPS-1 with history head..; each read
	// lands in the next cycle and feeds the registered multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			sub_q       <= '0;
			dptr_q      <= '0;
			out_valid_q <= 1'b0;
			clip_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept && in_data.mode == MODE_SAMPLE) begin
						head_q  <= head_prev;
						x_q     <= in_data.sample_in;
						cnt_q   <= '0;
						sub_q   <= '0;
						clip_q  <= 1'b0;
						state_q <= ST_LOWR;
					end
				end
				ST_LOWR, ST_MIDR: begin
					// sub 0: issuing reads; cnt counts issued taps.
					if (sub_q == 3'd0) begin
						if (cnt_q == (AW+1)'(TAPS)) begin
							sub_q <= 3'd1;
						end else begin
							cnt_q <= cnt_q + (AW+1)'(1);
						end
					end else if (sub_q == 3'd2) begin
						sub_q   <= '0;
						state_q <= (state_q == ST_LOWR) ? ST_LOWF : ST_MIDF;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_LOWF: begin
					if (sub_q == 3'd2) begin
						lowal_q <= ld_rd;
						rest_q  <= rest_sat[15:0];
						clip_q  <= clip_q | fir_sat[16] | rest_sat[16];
						cnt_q   <= '0;
						sub_q   <= '0;
						state_q <= ST_MIDR;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_MIDF: begin
					if (sub_q == 3'd2) begin
						mid_q   <= fir_sat[15:0];
						high_q  <= high_sat[15:0];
						clip_q  <= clip_q | fir_sat[16] | high_sat[16];
						sub_q   <= '0;
						dptr_q  <= (dptr_q == DW'(ALIGN - 1)) ? '0 : dptr_q + DW'(1);
						state_q <= ST_GAIN;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_GAIN: begin
					if (sub_q == 3'd4) begin
						sub_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q.eq_out    <= eq_sat[15:0];
						out_q.low_band  <= lowal_q;
						out_q.mid_band  <= mid_q;
						out_q.high_band <= high_q;
						out_q.clipped   <= clip_q | eq_sat[16];
						out_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Three-band FIR crossover equalizer testbench
// Drives samples and coefficient writes through the input channel under
// random bursts and gaps, stalls the output on its own pattern, and checks
// every result against a bit-accurate predictor of the crossover and the
// gain mix, across several gain settings written between phases.
// ---------------------------------------------------------------------------
module tb;
	import tbfe_pkg::*;

	localparam int TAPS = 63;
	localparam int ALIGN = (TAPS - 1) / 2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	three_band_fir_crossover_eq #(.TAPS(TAPS)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	int gain_bass = 4096, gain_mid = 4096, gain_treble = 4096;
	int hist_lo[TAPS], hist_mid[TAPS], coef_lo[TAPS], coef_mid[TAPS];
	int dly_low[ALIGN], dly_in[ALIGN], dly_rest[ALIGN];

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int fails = 0, samples_checked = 0, coef_writes = 0, clips_seen = 0;
	bit pause_sender = 0, hold_request = 0, hold_done = 0, took = 0;

	function automatic int clamp16(longint v, inout bit f);
		if (v > 32767) begin
			f = 1;
			return 32767;
		end
		if (v < -32768) begin
			f = 1;
			return -32768;
		end
		return int'(v);
	endfunction

	function automatic int filter_step(ref int h[TAPS], ref int c[TAPS], input int x,
			inout bit f);
		longint acc;
		acc = 0;
		for (int i = TAPS - 1; i > 0; i--) h[i] = h[i - 1];
		h[0] = x;
		for (int i = 0; i < TAPS; i++) acc += longint'(c[i]) * longint'(h[i]);
		return clamp16((acc + 16384) >>> 15, f);
	endfunction

	function automatic int delay_step(ref int d[ALIGN], input int x);
		int y;
		y = d[ALIGN - 1];
		for (int i = ALIGN - 1; i > 0; i--) d[i] = d[i - 1];
		d[0] = x;
		return y;
	endfunction

	function automatic void equalize(input in_item_t it);
		bit f;
		int x, lo, lo_al, dx, rest, md, drest, hi, y;
		longint sum;
		out_item_t r;
		f = 0;
		if (it.mode == MODE_LOW_COEF || it.mode == MODE_MID_COEF) begin
			coef_writes++;
			if (it.tap_index < TAPS) begin
				if (it.mode == MODE_LOW_COEF) coef_lo[it.tap_index] = it.tap_value;
				else coef_mid[it.tap_index] = it.tap_value;
			end
			return;
		end
		if (it.mode != MODE_SAMPLE) return;
		x = it.sample_in;
		lo = filter_step(hist_lo, coef_lo, x, f);
		lo_al = delay_step(dly_low, lo);
		dx = delay_step(dly_in, x);
		rest = clamp16(longint'(dx) - lo, f);
		md = filter_step(hist_mid, coef_mid, rest, f);
		drest = delay_step(dly_rest, rest);
		hi = clamp16(longint'(drest) - md, f);
		sum = longint'(gain_bass) * lo_al + longint'(gain_mid) * md
			+ longint'(gain_treble) * hi;
		y = clamp16((sum + 4096) >>> 13, f);
		r.eq_out = y[15:0];
		r.low_band = lo_al[15:0];
		r.mid_band = md[15:0];
		r.high_band = hi[15:0];
		r.clipped = f;
		expected_results.push_back(r);
	endfunction

	// Input acceptance and prediction
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			took = 1;
			equalize(in_data);
		end
	end

	// Sender: bursts of random length separated by random gaps
	int burst_left = 4, gap_left = 0;
	always @(negedge clk) begin
		if (in_valid && !took) begin
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pause_sender || pending_items.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			in_data <= pending_items.pop_front();
			in_valid <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
			end
		end
		took = 0;
	end

	// Receiver: stall pattern changes every so often, plus one long hold
	int pattern = 0, pattern_left = 0, hold_left = 0;
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done = 1;
			hold_left = 3000;
		end
		if (pattern_left == 0) begin
			pattern = $urandom_range(0, 3);
			pattern_left = $urandom_range(50, 600);
		end
		pattern_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (pattern)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ($urandom_range(0, 99) < 98);
			endcase
		end
	end

	// Result checking
	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction eq_out=%0d", out_data.eq_out);
				fails++;
			end else begin
				e = expected_results.pop_front();
				samples_checked++;
				if (out_data.clipped) clips_seen++;
				if (out_data.eq_out !== e.eq_out) begin
					$error("eq_out expected %0d got %0d", e.eq_out, out_data.eq_out);
					fails++;
				end
				if (out_data.low_band !== e.low_band) begin
					$error("low_band expected %0d got %0d", e.low_band, out_data.low_band);
					fails++;
				end
				if (out_data.mid_band !== e.mid_band) begin
					$error("mid_band expected %0d got %0d", e.mid_band, out_data.mid_band);
					fails++;
				end
				if (out_data.high_band !== e.high_band) begin
					$error("high_band expected %0d got %0d", e.high_band,
						out_data.high_band);
					fails++;
				end
				if (out_data.clipped !== e.clipped) begin
					$error("clipped expected %0d got %0d", e.clipped, out_data.clipped);
					fails++;
				end
			end
		end
	end

	function automatic in_item_t make_item(logic [1:0] m, int s, int idx, int v);
		in_item_t it;
		it.mode = m;
		it.sample_in = s[15:0];
		it.tap_index = idx[5:0];
		it.tap_value = v[15:0];
		return it;
	endfunction

	function automatic in_item_t random_item();
		int r, v, s;
		in_item_t it;
		it.sample_in = 16'($urandom);
		r = $urandom_range(0, 99);
		v = ($urandom_range(0, 4) == 0) ? int'($urandom) : $urandom_range(0, 4095) - 2048;
		it.tap_value = v[15:0];
		if (r < 2) it.mode = MODE_UNUSED;
		else if (r < 12) it.mode = MODE_LOW_COEF;
		else if (r < 22) it.mode = MODE_MID_COEF;
		else it.mode = MODE_SAMPLE;
		it.tap_index = ($urandom_range(0, 19) == 0) ? 6'd63 : 6'($urandom_range(0, 62));
		if ($urandom_range(0, 9) == 0) begin
			s = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
			it.sample_in = s[15:0];
		end
		return it;
	endfunction

	task automatic write_gain(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[15:0];
		if (idx == CFG_BASS) gain_bass = value & 16'hFFFF;
		else if (idx == CFG_MIDDLE) gain_mid = value & 16'hFFFF;
		else if (idx == CFG_TREBLE) gain_treble = value & 16'hFFFF;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) pending_items.push_back(random_item());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every mode, ignored writes, forced clipping
		pending_items.push_back(make_item(MODE_SAMPLE, 32767, 0, 0));
		pending_items.push_back(make_item(MODE_SAMPLE, -32768, 0, 0));
		pending_items.push_back(make_item(MODE_SAMPLE, 0, 63, -1));
		pending_items.push_back(make_item(MODE_LOW_COEF, 0, 0, 32767));
		pending_items.push_back(make_item(MODE_LOW_COEF, 0, 62, -32768));
		pending_items.push_back(make_item(MODE_LOW_COEF, 0, 63, 12345));
		pending_items.push_back(make_item(MODE_MID_COEF, 0, 0, -32768));
		pending_items.push_back(make_item(MODE_MID_COEF, 0, 62, 32767));
		pending_items.push_back(make_item(MODE_MID_COEF, 0, 63, -7));
		pending_items.push_back(make_item(MODE_UNUSED, -1, 63, -1));
		pending_items.push_back(make_item(MODE_SAMPLE, 32767, 0, 0));
		pending_items.push_back(make_item(MODE_SAMPLE, -32768, 0, 0));
		pending_items.push_back(make_item(MODE_SAMPLE, -32768, 0, 0));
		pending_items.push_back(make_item(MODE_LOW_COEF, 0, 0, -32768));
		pending_items.push_back(make_item(MODE_SAMPLE, -32768, 0, 0));
		pending_items.push_back(make_item(MODE_SAMPLE, 32767, 0, 0));
		pending_items.push_back(make_item(MODE_LOW_COEF, 0, 31, 16384));
		pending_items.push_back(make_item(MODE_MID_COEF, 0, 31, 8192));
		for (int i = 0; i < 6; i++)
			pending_items.push_back(make_item(MODE_SAMPLE, int'($urandom), 0, 0));
		wait_idle();

		write_gain(CFG_BASS, 65535);
		write_gain(CFG_MIDDLE, 65535);
		write_gain(CFG_TREBLE, 65535);
		random_phase(200);
		wait (pending_items.size() < 120);
		hold_request = 1;
		wait (hold_done);
		wait (pending_items.size() < 60);
		pause_sender = 1;
		while (in_valid || expected_results.size() != 0) @(posedge clk);
		pause_sender = 0;
		wait_idle();

		write_gain(CFG_BASS, 0);
		write_gain(CFG_MIDDLE, 0);
		write_gain(CFG_TREBLE, 0);
		write_gain(CFG_UNUSED, 16'h5A5A);
		random_phase(200);
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			write_gain(CFG_BASS, $urandom_range(0, 65535));
			write_gain(CFG_MIDDLE, (p == 0) ? 4096 : $urandom_range(0, 16384));
			write_gain(CFG_TREBLE, $urandom_range(0, 8192));
			random_phase(220);
			wait_idle();
		end

		repeat (300) @(posedge clk);
		$display("Checked %0d equalized samples (%0d clipped) and %0d coefficient writes",
			samples_checked, clips_seen, coef_writes);
		$display("over seven gain settings, extremes included, with random flow control.");
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
